// ===== rtl/integer_to_ascii_formatter_defines.svh =====
// assertion macros for the integer to ascii formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ITA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ITA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ITA_ASSERT(lbl, clk, rst, prop)
`define ITA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/ita_pkg.sv =====
// shared types, codes and constants of the integer to ascii formatter
`timescale 1ns / 1ps
`default_nettype none

package ita_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;

   localparam logic [1:0] ACTION_SDEC = 2'd0;
   localparam logic [1:0] ACTION_UDEC = 2'd1;
   localparam logic [1:0] ACTION_HEX  = 2'd2;

   localparam logic [1:0] PAD_RIGHT = 2'd0;
   localparam logic [1:0] PAD_LEFT  = 2'd1;
   localparam logic [1:0] PAD_ZERO  = 2'd2;
   localparam logic [1:0] PAD_NONE  = 2'd3;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   localparam logic [15:0][7:0] HEX_CHARS = "fedcba9876543210";

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD_DEC,
      OP_LOAD_HEX,
      OP_DABBLE,
      OP_SHIFT
   } op_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] value;
      logic [1:0]  pad_mode;
      logic [3:0]  field_width;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      digit_char = HEX_CHARS[d];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ita_shift_unit.sv =====
// shared shift-and-adjust unit: binary to bcd conversion and digit shift-out
`timescale 1ns / 1ps
`default_nettype none

module ita_shift_unit #(
   parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEFAULT,
   parameter int DIGITS     = 20
) (
   input  wire logic                  clock,
   input  wire ita_pkg::op_type       op,
   input  wire logic [VALUE_BITS-1:0] load_value,
   output logic [3:0]                 top_digit
);

   localparam int DW = 4 * DIGITS;

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [DW-1:0]         dig_ff, dig_in;
   logic [DW-1:0]         adj;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      dig_in = dig_ff;
      unique case (op)
         ita_pkg::OP_HOLD: begin
         end
         ita_pkg::OP_LOAD_DEC: begin
            bin_in = load_value;
            dig_in = '0;
         end
         ita_pkg::OP_LOAD_HEX: begin
            bin_in = load_value;
            dig_in = {{(DW-VALUE_BITS){1'b0}}, load_value};
         end
         ita_pkg::OP_DABBLE: begin
            bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
            dig_in = {adj[DW-2:0], bin_ff[VALUE_BITS-1]};
         end
         ita_pkg::OP_SHIFT: begin
            dig_in = {dig_ff[DW-5:0], 4'd0};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      dig_ff <= dig_in;
   end

   assign top_digit = dig_ff[DW-1 -: 4];

endmodule

`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
// top level of the integer to ascii formatter
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"

// Converts one number per command into its ASCII characters, one character per
// cycle on rsp_data with rsp_valid high for that cycle; the final character has
// last set. The receiver cannot stall, so it must take every strobed character.
// A command is taken when start is high and busy is low; busy stays high until
// the last character is out. Decimal conversion runs on the shared
// shift-and-add-3 unit, one value bit per cycle; hex values are loaded into it
// directly. Leading zero digits are then stripped one per cycle (at most
// DIGITS-1 of them, DIGITS being 20 at 64 bits), and the characters follow one
// per cycle.

module integer_to_ascii_formatter #(
   parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ita_pkg::req_type req_data,
   output logic                  rsp_valid,
   output ita_pkg::rsp_type      rsp_data
);

   localparam int DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
   localparam int MAXTOT = (DIGITS + 1 > 15) ? DIGITS + 1 : 15;
   localparam int CW     = $clog2(MAXTOT + 1);
   localparam int NW     = $clog2(DIGITS + 1);
   localparam int BW     = $clog2(VALUE_BITS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_NORM,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic              neg_ff, neg_in;
   logic [1:0]        pad_ff, pad_in;
   logic [3:0]        width_ff, width_in;
   logic [NW-1:0]     nd_ff, nd_in;
   logic [BW-1:0]     bits_ff, bits_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ita_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   ita_pkg::op_type        op;
   logic [VALUE_BITS-1:0]  raw;
   logic [VALUE_BITS-1:0]  load_value;
   logic                   is_neg;
   logic [3:0]             top_digit;
   logic [CW-1:0]          body;
   logic [CW-1:0]          width_ext;

   assign raw        = req_data.value[VALUE_BITS-1:0];
   assign is_neg     = (req_data.action == ita_pkg::ACTION_SDEC) && raw[VALUE_BITS-1];
   assign load_value = is_neg ? (~raw + 1'b1) : raw;
   assign body       = CW'(nd_ff) + CW'(neg_ff);
   assign width_ext  = CW'(width_ff);

   ita_shift_unit #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_shift (
      .clock      (clock),
      .op         (op),
      .load_value (load_value),
      .top_digit  (top_digit)
   );

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      pad_in       = pad_ff;
      width_in     = width_ff;
      nd_in        = nd_ff;
      bits_in      = bits_ff;
      fill_in      = fill_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      op           = ita_pkg::OP_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               neg_in   = is_neg;
               pad_in   = (req_data.pad_mode == ita_pkg::PAD_NONE) ?
                          ita_pkg::PAD_RIGHT : req_data.pad_mode;
               width_in = req_data.field_width;
               nd_in    = NW'(DIGITS);
               bits_in  = BW'(VALUE_BITS);
               if (req_data.action[1]) begin
                  op       = ita_pkg::OP_LOAD_HEX;
                  state_in = S_NORM;
               end else begin
                  op       = ita_pkg::OP_LOAD_DEC;
                  state_in = S_CONV;
               end
            end
         end
         S_CONV: begin
            op      = ita_pkg::OP_DABBLE;
            bits_in = bits_ff - 1'b1;
            if (bits_ff == BW'(1)) begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if ((nd_ff > NW'(1)) && (top_digit == 4'd0)) begin
               op    = ita_pkg::OP_SHIFT;
               nd_in = nd_ff - 1'b1;
            end else begin
               if (width_ext > body) begin
                  rem_in  = width_ext;
                  fill_in = width_ext - body;
               end else begin
                  rem_in  = body;
                  fill_in = '0;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_valid_in     = 1'b1;
            rem_in           = rem_ff - 1'b1;
            rsp_data_in.last = (rem_ff == CW'(1));
            if ((pad_ff == ita_pkg::PAD_RIGHT) && (fill_ff != '0)) begin
               rsp_data_in.out_char = ita_pkg::CHAR_SPACE;
               fill_in              = fill_ff - 1'b1;
            end else if (neg_ff) begin
               rsp_data_in.out_char = ita_pkg::CHAR_MINUS;
               neg_in               = 1'b0;
            end else if ((pad_ff == ita_pkg::PAD_ZERO) && (fill_ff != '0)) begin
               rsp_data_in.out_char = ita_pkg::CHAR_ZERO;
               fill_in              = fill_ff - 1'b1;
            end else if (nd_ff != '0) begin
               rsp_data_in.out_char = ita_pkg::digit_char(top_digit);
               op                   = ita_pkg::OP_SHIFT;
               nd_in                = nd_ff - 1'b1;
            end else begin
               rsp_data_in.out_char = ita_pkg::CHAR_SPACE;
               fill_in              = fill_ff - 1'b1;
            end
            if (rem_ff == CW'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      pad_ff      <= pad_in;
      width_ff    <= width_in;
      nd_ff       <= nd_in;
      bits_ff     <= bits_in;
      fill_ff     <= fill_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new transfer never starts with a character in the next cycle
   `ITA_ASSERT(a_accept_quiet, clock, reset, (start && !busy) |=> !rsp_valid)
   // nothing follows the final character
   `ITA_ASSERT(a_last_ends, clock, reset, (rsp_valid && rsp_data.last) |=> !rsp_valid)
   // no characters while converting
   `ITA_ASSERT_IMPL(a_conv_quiet, clock, reset, state_ff == S_CONV, !rsp_valid)
   // at least one digit survives zero stripping
   `ITA_ASSERT_IMPL(a_norm_digits, clock, reset, state_ff == S_NORM, nd_ff != '0)

endmodule

`default_nettype wire
